/* rtl/core/longest_ones_with_k_flips_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the longest-ones block
// Clocked on clk; the first form is masked while rst is high.
// ----------------------------------------------------------------------------
`ifndef LONGEST_ONES_WITH_K_FLIPS_UNIT_DEFINES_SVH
`define LONGEST_ONES_WITH_K_FLIPS_UNIT_DEFINES_SVH

// checked only outside reset
`define LOWKF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define LOWKF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/lowkf_pkg.sv */
// ----------------------------------------------------------------------------
// lowkf_pkg
// Shared widths, defaults and the zero-queue control word.
// ----------------------------------------------------------------------------
package lowkf_pkg;

  localparam int unsigned MAX_LEN_DEFAULT    = 32'd65535;
  localparam int          ZERO_DEPTH_DEFAULT = 256;
  localparam int          FLIPS_W            = 8;
  localparam int          LEN_W              = 16;

  typedef struct packed {
    logic step;   // a word was accepted this cycle
    logic push;   // that word is a zero
    logic clear;  // that word closes the array
  } qctrl_t;

endpackage

/* rtl/core/lowkf_zero_queue.sv */
// ----------------------------------------------------------------------------
// lowkf_zero_queue
// Circular queue of zero positions with the oldest entry held in a register
// and the one after it prefetched from the memory, so a push and a pop can
// both happen every cycle.
// ----------------------------------------------------------------------------
module lowkf_zero_queue #(
  parameter int DEPTH = lowkf_pkg::ZERO_DEPTH_DEFAULT,
  parameter int POS_W = lowkf_pkg::LEN_W
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lowkf_pkg::qctrl_t            ctrl,
  input  logic [POS_W-1:0]             push_value,
  input  logic [lowkf_pkg::FLIPS_W-1:0] flip_limit,
  output logic                         pop,
  output logic [POS_W-1:0]             oldest
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int LIM_W = (CNT_W > lowkf_pkg::FLIPS_W) ? CNT_W : lowkf_pkg::FLIPS_W;

  logic [POS_W-1:0] mem [DEPTH];
  logic [IDX_W-1:0] head, head_next;
  logic [CNT_W-1:0] count, count_next;
  logic [POS_W-1:0] head_pos, head_pos_next;
  logic [POS_W-1:0] rd_data;

  logic [CNT_W-1:0] cnt_push;
  logic [LIM_W-1:0] limit;
  logic [IDX_W:0]   slot_sum;
  logic [IDX_W-1:0] slot;
  logic [IDX_W-1:0] head_inc;
  logic [IDX_W-1:0] rd_addr;

  always_comb begin
    cnt_push = count + CNT_W'(ctrl.push);
    if (LIM_W'(flip_limit) > LIM_W'(DEPTH - 1)) begin
      limit = LIM_W'(DEPTH - 1);
    end else begin
      limit = LIM_W'(flip_limit);
    end
    pop = ctrl.step && (LIM_W'(cnt_push) > limit);

    slot_sum = (IDX_W+1)'(head) + (IDX_W+1)'(count);
    if (slot_sum >= (IDX_W+1)'(DEPTH)) begin
      slot = IDX_W'(slot_sum - (IDX_W+1)'(DEPTH));
    end else begin
      slot = slot_sum[IDX_W-1:0];
    end

    // empty queue: the zero pushed now is the oldest one
    oldest = (count == '0) ? push_value : head_pos;

    head_inc = (head == IDX_W'(DEPTH - 1)) ? '0 : head + IDX_W'(1);

    if (ctrl.clear) begin
      head_next  = '0;
      count_next = '0;
    end else if (ctrl.step) begin
      head_next  = pop ? head_inc : head;
      count_next = cnt_push - CNT_W'(pop);
    end else begin
      head_next  = head;
      count_next = count;
    end

    head_pos_next = head_pos;
    if (pop) begin
      head_pos_next = (count >= CNT_W'(2)) ? rd_data : push_value;
    end else if (ctrl.push && count == '0) begin
      head_pos_next = push_value;
    end

    // prefetch the entry behind the next head
    rd_addr = (head_next == IDX_W'(DEPTH - 1)) ? '0 : head_next + IDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    head_pos <= head_pos_next;
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[slot] <= push_value;
    end
    if (ctrl.push && slot == rd_addr) begin
      rd_data <= push_value;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/longest_ones_with_k_flips_unit.sv */
// ----------------------------------------------------------------------------
// longest_ones_with_k_flips_unit
// Longest window of a bit stream holding at most max_flips zeros.
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// input    in         in_valid / in_ready    bit_value, is_last
// result   out        out_valid / out_ready  longest_length
// config   in         max_flips_we           max_flips
//
// One word per cycle while in_ready is high; the result word is registered as the
// last word is accepted. The zero queue keeps its oldest entry in a register and
// prefetches the next from its memory, so one push and one pop fit each cycle.
// in_ready drops only while a finished result waits and out_ready is low.
// Reset (synchronous) clears all counters; the queue memory needs no clearing.
// ----------------------------------------------------------------------------
module longest_ones_with_k_flips_unit #(
  parameter int unsigned MAX_LEN    = lowkf_pkg::MAX_LEN_DEFAULT,
  parameter int          ZERO_DEPTH = lowkf_pkg::ZERO_DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          max_flips_we,
  input  logic [lowkf_pkg::FLIPS_W-1:0] max_flips,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          bit_value,
  input  logic                          is_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lowkf_pkg::LEN_W-1:0]   longest_length
);

  localparam int POS_W = $clog2(64'(MAX_LEN) + 64'd1);

  logic [lowkf_pkg::FLIPS_W-1:0] flip_limit;
  logic [POS_W-1:0] position, position_next;
  logic [POS_W:0]   window_start, window_start_next;
  logic [POS_W-1:0] best_length, best_length_next;
  logic             out_valid_next;

  logic              accept;
  lowkf_pkg::qctrl_t qctrl;
  logic              pop;
  logic [POS_W-1:0]  oldest;
  logic [POS_W:0]    span;
  logic [POS_W-1:0]  len;
  logic [POS_W-1:0]  best_step;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign qctrl.step  = accept;
  assign qctrl.push  = accept && !bit_value;
  assign qctrl.clear = accept && is_last;

  lowkf_zero_queue #(
    .DEPTH (ZERO_DEPTH),
    .POS_W (POS_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (qctrl),
    .push_value (position),
    .flip_limit (flip_limit),
    .pop        (pop),
    .oldest     (oldest)
  );

  always_comb begin
    span = '0;
    if (pop) begin
      // window now starts just after the dropped zero
      len = (position > oldest) ? position - oldest : '0;
    end else if ((POS_W+1)'(position) >= window_start) begin
      span = (POS_W+1)'(position) - window_start + (POS_W+1)'(1);
      if (span > (POS_W+1)'(MAX_LEN)) begin
        len = POS_W'(MAX_LEN);
      end else begin
        len = span[POS_W-1:0];
      end
    end else begin
      len = '0;
    end
    best_step = (len > best_length) ? len : best_length;

    position_next     = position;
    window_start_next = window_start;
    best_length_next  = best_length;
    if (accept) begin
      if (is_last) begin
        position_next     = '0;
        window_start_next = '0;
        best_length_next  = '0;
      end else begin
        position_next = (position == POS_W'(MAX_LEN)) ? position : position + POS_W'(1);
        if (pop) begin
          window_start_next = (POS_W+1)'(oldest) + (POS_W+1)'(1);
        end
        best_length_next = best_step;
      end
    end

    if (accept && is_last) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flip_limit   <= '0;
      position     <= '0;
      window_start <= '0;
      best_length  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (max_flips_we) begin
        flip_limit <= max_flips;
      end
      position     <= position_next;
      window_start <= window_start_next;
      best_length  <= best_length_next;
      out_valid    <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_last) begin
      longest_length <= lowkf_pkg::LEN_W'(best_step);
    end
  end

endmodule

/* rtl/core/lowkf_checker.sv */
// ----------------------------------------------------------------------------
// lowkf_checker
// Port-level checks on the longest-ones block, bound to its top level.
// ----------------------------------------------------------------------------
`include "longest_ones_with_k_flips_unit_defines.svh"

module lowkf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        is_last,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [lowkf_pkg::LEN_W-1:0] longest_length
);

  logic last_acc;
  logic out_stall;

  assign last_acc  = in_valid && in_ready && is_last;
  assign out_stall = out_valid && !out_ready;

  `LOWKF_ASSERT_ALWAYS(a_reset_empties_output, rst |=> !out_valid, "result word after reset")
  `LOWKF_ASSERT(a_last_gives_result, last_acc |=> out_valid, "last word lost")
  `LOWKF_ASSERT(a_result_from_last, $rose(out_valid) |-> $past(last_acc), "stray result")
  `LOWKF_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with empty output")
  `LOWKF_ASSERT(a_result_held, out_stall |=> out_valid && $stable(longest_length), "result moved")

endmodule

bind longest_ones_with_k_flips_unit lowkf_checker u_checker (.*);

/* verif/longest_ones_with_k_flips_unit_test.sv */
// ----------------------------------------------------------------------------
// longest_ones_with_k_flips_unit_test
// Streams bit arrays into the block under random idling on both channels and
// checks each reported window length against a sliding-window predictor.
// ----------------------------------------------------------------------------
module longest_ones_with_k_flips_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          ZQ_DEPTH     = lowkf_pkg::ZERO_DEPTH_DEFAULT;
  localparam int unsigned LEN_CEIL     = lowkf_pkg::MAX_LEN_DEFAULT;
  localparam int          SETTLE       = 4;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          PHASE_WORDS  = 60;
  localparam int          CYCLE_LIMIT  = 1_000_000;

  logic                          clk;
  logic                          rst;
  logic                          max_flips_we;
  logic [lowkf_pkg::FLIPS_W-1:0] max_flips;
  logic                          in_valid;
  logic                          in_ready;
  logic                          bit_value;
  logic                          is_last;
  logic                          out_valid;
  logic                          out_ready;
  logic [lowkf_pkg::LEN_W-1:0]   longest_length;

  longest_ones_with_k_flips_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .max_flips_we  (max_flips_we),
    .max_flips     (max_flips),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .bit_value     (bit_value),
    .is_last       (is_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .longest_length(longest_length)
  );

  // Window tracker plus the lengths still owed by the block.
  class length_board;
    logic [lowkf_pkg::FLIPS_W-1:0] flips;
    int unsigned                   pos;
    int unsigned                   win_start;
    int unsigned                   zcount;
    int unsigned                   best;
    int unsigned                   qhead;
    int unsigned                   zpos [ZQ_DEPTH];
    logic [lowkf_pkg::LEN_W-1:0]   pending_lengths [$];
    int unsigned                   fail_count;

    function void clear_run();
      pos       = 0;
      win_start = 0;
      zcount    = 0;
      best      = 0;
      qhead     = 0;
    endfunction

    function void init();
      flips      = '0;
      fail_count = 0;
      clear_run();
    endfunction

    function void set_flips(logic [lowkf_pkg::FLIPS_W-1:0] v);
      flips = v;
    endfunction

    function void note_word(logic b, logic last);
      int unsigned lim;
      int unsigned span;
      lim = (flips > ZQ_DEPTH - 1) ? ZQ_DEPTH - 1 : flips;
      if (!b) begin
        zpos[(qhead + zcount) % ZQ_DEPTH] = pos;
        zcount++;
      end
      // too many zeros: window restarts just past the oldest one
      if (zcount > lim) begin
        win_start = zpos[qhead] + 1;
        qhead     = (qhead + 1) % ZQ_DEPTH;
        zcount--;
      end
      span = (pos >= win_start) ? pos - win_start + 1 : 0;
      if (span > LEN_CEIL) span = LEN_CEIL;
      if (span > best) best = span;
      if (pos < LEN_CEIL) pos++;
      if (last) begin
        pending_lengths.push_back(best[lowkf_pkg::LEN_W-1:0]);
        clear_run();
      end
    endfunction

    function void check_length(logic [lowkf_pkg::LEN_W-1:0] got);
      logic [lowkf_pkg::LEN_W-1:0] want;
      if (pending_lengths.size() == 0) begin
        $error("longest_length: expected none, actual %0d", got);
        fail_count++;
      end else begin
        want = pending_lengths.pop_front();
        if (got !== want) begin
          $error("longest_length: expected %0d, actual %0d", want, got);
          fail_count++;
        end
      end
    endfunction
  endclass

  length_board board;
  bit          hold_request;
  bit          hold_active;
  int unsigned cycles = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) board.check_length(longest_length);
      if (in_valid && in_ready) board.note_word(bit_value, is_last);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input logic b, input logic last, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    bit_value <= b;
    is_last   <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_pattern(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_word(s[i] == "1", i == s.len() - 1, pick_gap());
    end
  endtask

  task automatic send_random_array(input int len, input int zero_pct, input bit tight);
    for (int i = 0; i < len; i++) begin
      send_word($urandom_range(0, 99) >= zero_pct, i == len - 1, tight ? 0 : pick_gap());
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_lengths.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_flips(input logic [lowkf_pkg::FLIPS_W-1:0] v);
    drain();
    max_flips_we <= 1'b1;
    max_flips    <= v;
    @(negedge clk);
    max_flips_we <= 1'b0;
    board.set_flips(v);
  endtask

  initial begin : receiver
    int stretch;
    int pick;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_active  = 1'b1;
        out_ready   <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_active  = 1'b0;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          out_ready <= 1'b1;
          stretch = $urandom_range(1, 4);
        end else if (pick < 80) begin
          out_ready <= 1'b0;
          stretch = $urandom_range(1, 3);
        end else if (pick < 93) begin
          out_ready <= 1'b1;
          stretch = $urandom_range(20, 80);
        end else begin
          out_ready <= 1'b0;
          stretch = $urandom_range(10, 40);
        end
        repeat (stretch) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [lowkf_pkg::FLIPS_W-1:0] flip_plan [9];
    int words;
    int len;
    int r;
    int zero_pct;
    board = new();
    board.init();
    rst          = 1'b1;
    max_flips_we = 1'b0;
    max_flips    = '0;
    in_valid     = 1'b0;
    bit_value    = 1'b0;
    is_last      = 1'b0;
    hold_request = 1'b0;
    hold_active  = 1'b0;
    flip_plan = '{8'd1, 8'd2, 8'd3, 8'd255, 8'd0, 8'hAA, 8'h55,
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset limit of zero: single words, plain runs; then limits of 1 and 255
    send_pattern("1");
    send_pattern("0");
    send_pattern("110111");
    write_flips(8'd1);
    send_pattern("00");
    send_pattern("1011011");
    write_flips(8'd255);
    send_pattern("00010");

    // back to no flips
    write_flips(8'd0);
    send_pattern("0011");

    foreach (flip_plan[p]) begin
      write_flips(flip_plan[p]);
      words = 0;
      // enough zeros to wrap the queue slots at the deepest limit
      if (flip_plan[p] == 8'd255) begin
        send_random_array(400, 80, 1'b0);
        words += 400;
      end
      if (p == 1) begin
        hold_request = 1'b1;
        wait (hold_active);
        for (int a = 0; a < 15; a++) begin
          len = $urandom_range(1, 4);
          send_random_array(len, 40, 1'b1);
          words += len;
        end
      end
      while (words < PHASE_WORDS) begin
        r = $urandom_range(0, 99);
        if (r < 70)      len = $urandom_range(1, 16);
        else if (r < 92) len = $urandom_range(17, 80);
        else             len = $urandom_range(81, 400);
        case ($urandom_range(0, 5))
          0: zero_pct = 0;
          1: zero_pct = 10;
          2: zero_pct = 30;
          3: zero_pct = 50;
          4: zero_pct = 80;
          default: zero_pct = 100;
        endcase
        send_random_array(len, zero_pct, $urandom_range(0, 3) == 0);
        words += len;
        // occasionally let the result side run dry mid-phase
        if ($urandom_range(0, 19) == 0) drain();
      end
    end

    drain();
    repeat (20) @(negedge clk);
    if (board.fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/lowkf_pkg.sv
rtl/core/lowkf_zero_queue.sv
rtl/core/longest_ones_with_k_flips_unit.sv
rtl/core/lowkf_checker.sv
verif/longest_ones_with_k_flips_unit_test.sv
